// ===== sv/sos_pkg.sv =====
package sos_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_ROWS_DEF   = 8;
    localparam int MAX_COLS_DEF   = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // Top level control
    typedef enum logic
    {
        ST_LOAD,
        ST_WALK
    } scan_state_t;

    // Side of the spiral being walked
    typedef enum logic [1:0]
    {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } walk_dir_t;

    // Zero reads as one, anything above the maximum reads as the maximum
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        if (v == '0)
        begin
            r = {{(CFG_W-1){1'b0}}, 1'b1};
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== sv/sos_ram.sv =====
module sos_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/spiral_order_scan_core.sv =====
// Spiral order scan core.
// A matrix of row_count x column_count elements (each clamped to 1..MAX) is loaded
// one item per cycle on the input channel (in_valid/in_ready), in row-major order,
// into a single-port-write, registered-read RAM. The item that completes the
// matrix starts the walk: while the output buffer has room, the RAM is read once
// per cycle in clockwise spiral order and the data goes out on the output channel
// (out_valid/out_ready), with is_last set on the final item of the run.
// After the last element is accepted, the first result passes through address
// issue, RAM read and the output buffer. Loading and the walk do not overlap, and
// the RAM read port sets the walk rate. in_ready is low while the walk issues
// reads and returns high the cycle after the last read, while results may still
// drain from the 2-entry output buffer.
// When the receiver stalls, the output buffer fills and the walk pauses; nothing
// is dropped and the held item stays unchanged.
// Configuration (cfg_valid/cfg_ready, always ready) must be written only while idle;
// the block does not enforce this. Reset clears the load count and walk control and
// sets both sizes to 8; the RAM contents are not cleared and need no clearing pass.
module spiral_order_scan_core
    import sos_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] element_value,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] spiral_value,
    output logic                         is_last,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LCNT_W = $clog2(DEPTH + 1);

    localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);

    scan_state_t       state_reg, state_next;
    logic [CFG_W-1:0]  row_count_reg, column_count_reg;
    logic [CFG_W-1:0]  rows_c, cols_c;
    logic [LCNT_W-1:0] load_count_reg, load_count_next, load_inc, total;

    logic [ROW_W-1:0]  top_reg, bottom_reg, row_reg;
    logic [ROW_W-1:0]  top_next, bottom_next, row_next;
    logic [COL_W-1:0]  left_reg, right_reg, col_reg;
    logic [COL_W-1:0]  left_next, right_next, col_next;
    walk_dir_t         dir_reg, dir_next;

    logic              in_acc, load_done, issue, walk_end, pop;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic              pend_reg, pend_last_reg;
    logic [1:0]        occ;

    logic [DATA_WIDTH-1:0] fifo_data_reg [2];
    logic              fifo_last_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_RESET;
            column_count_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign rows_c = clamp_dim(row_count_reg, MAX_ROWS_C);
    assign cols_c = clamp_dim(column_count_reg, MAX_COLS_C);
    assign total  = LCNT_W'(rows_c) * LCNT_W'(cols_c);

    // Load side
    assign in_acc    = in_valid && in_ready;
    assign load_inc  = load_count_reg + 1'b1;
    assign load_done = in_acc && (load_inc >= total);

    always_comb
    begin
        load_count_next = load_count_reg;
        if (load_done)
        begin
            load_count_next = '0;
        end
        else if (in_acc)
        begin
            load_count_next = load_inc;
        end
    end

    // Output buffer occupancy once pending data lands; a read may issue if room stays
    assign pop   = out_valid && out_ready;
    assign occ   = count_reg + {1'b0, pend_reg} - {1'b0, pop};

    // State machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (load_done)        state_next = ST_WALK;
            ST_WALK: if (issue && walk_end) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // State machine: outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            ST_LOAD: in_ready = 1'b1;
            ST_WALK: issue    = (occ <= 2'd1);
            default: ;
        endcase
    end

    // Last element of the whole walk: the current side ends and its bounds meet
    always_comb
    begin
        case (dir_reg)
            DIR_RIGHT: walk_end = (col_reg == right_reg) && (top_reg == bottom_reg);
            DIR_DOWN:  walk_end = (row_reg == bottom_reg) && (left_reg == right_reg);
            DIR_LEFT:  walk_end = (col_reg == left_reg) && (top_reg == bottom_reg);
            default:   walk_end = (row_reg == top_reg) && (left_reg == right_reg);
        endcase
    end

    // Walk position and bounds
    always_comb
    begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        dir_next    = dir_reg;
        if (load_done)
        begin
            top_next    = '0;
            bottom_next = ROW_W'(rows_c - 1'b1);
            left_next   = '0;
            right_next  = COL_W'(cols_c - 1'b1);
            row_next    = '0;
            col_next    = '0;
            dir_next    = DIR_RIGHT;
        end
        else if (issue)
        begin
            case (dir_reg)
                DIR_RIGHT:
                begin
                    if (col_reg != right_reg)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        top_next = top_reg + 1'b1;
                        row_next = top_reg + 1'b1;
                        dir_next = DIR_DOWN;
                    end
                end
                DIR_DOWN:
                begin
                    if (row_reg != bottom_reg)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        right_next = right_reg - 1'b1;
                        col_next   = right_reg - 1'b1;
                        dir_next   = DIR_LEFT;
                    end
                end
                DIR_LEFT:
                begin
                    if (col_reg != left_reg)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                    else
                    begin
                        bottom_next = bottom_reg - 1'b1;
                        row_next    = bottom_reg - 1'b1;
                        dir_next    = DIR_UP;
                    end
                end
                default:
                begin
                    if (row_reg != top_reg)
                    begin
                        row_next = row_reg - 1'b1;
                    end
                    else
                    begin
                        left_next = left_reg + 1'b1;
                        col_next  = left_reg + 1'b1;
                        dir_next  = DIR_RIGHT;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            dir_reg        <= DIR_RIGHT;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            dir_reg        <= dir_next;
            pend_reg       <= issue;
            pend_last_reg  <= issue && walk_end;
        end
    end

    // Element store
    assign rd_addr = ADDR_W'(row_reg) * ADDR_W'(cols_c) + ADDR_W'(col_reg);

    sos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (load_count_reg[ADDR_W-1:0]),
        .wr_data (element_value),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Two-entry output buffer: pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (pend_reg)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, pend_reg} - {1'b0, pop};
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            fifo_data_reg[wr_ptr_reg] <= rd_data;
            fifo_last_reg[wr_ptr_reg] <= pend_last_reg;
        end
    end

    assign out_valid    = (count_reg != 2'd0);
    assign spiral_value = fifo_data_reg[rd_ptr_reg];
    assign is_last      = fifo_last_reg[rd_ptr_reg];

endmodule

// ===== sv/sos_checker.sv =====
module sos_checker
    import sos_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] spiral_value,
    input logic                         is_last
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int OCNT_W = $clog2(DEPTH + 1);
    localparam int CRED_W = $clog2(8 * DEPTH) + 1;

    logic              out_acc;
    logic              in_acc;
    logic              last_acc;
    logic [OCNT_W-1:0] out_cnt_reg;
    logic [CRED_W-1:0] credit_reg;

    assign out_acc  = out_valid && out_ready;
    assign in_acc   = in_valid && in_ready;
    assign last_acc = out_acc && is_last;

    // Items delivered in the current run; elements taken and not yet closed by a finished run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
            credit_reg  <= '0;
        end
        else
        begin
            if (out_acc)
            begin
                out_cnt_reg <= is_last ? '0 : out_cnt_reg + 1'b1;
            end
            credit_reg <= credit_reg + CRED_W'(in_acc) - CRED_W'(last_acc);
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(spiral_value) && $stable(is_last))
        else $error("output item changed while stalled");

    // No run is longer than the store
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_cnt_reg == OCNT_W'(DEPTH - 1)) |-> is_last)
        else $error("spiral run longer than the matrix store");

    // Every result needs more elements taken than runs already finished
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0))
        else $error("result item without a new load");

endmodule

bind spiral_order_scan_core sos_checker #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
) u_sos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .spiral_value (spiral_value),
    .is_last      (is_last)
);
